// ===== design/gcv_pkg.sv =====
// ----------------------------------------------------------------------------
// gcv_pkg: shared types and constants for the contour flattener
// Tags, field widths, controller state and the command/status structs.
// ----------------------------------------------------------------------------
package gcv_pkg;

  localparam int unsigned MaxPointsDefault = 32;
  localparam int unsigned CoordW = 24;
  localparam int unsigned VertW  = 27;
  localparam int unsigned TagW   = 2;

  localparam logic [TagW-1:0] TagOn     = 2'd0;
  localparam logic [TagW-1:0] TagConic  = 2'd1;
  localparam logic [TagW-1:0] TagCubic  = 2'd2;
  localparam logic [TagW-1:0] TagUnused = 2'd3;

  typedef enum logic [2:0] {
    StCollect,
    StEval,
    StEmitPre,
    StEmitPt,
    StWaitFinal
  } state_e;

  typedef enum logic [1:0] {
    PreNone,
    PreMid,
    PreCubic
  } pre_e;

  // controller -> datapath
  typedef struct packed {
    logic       store;    // write input word to point store
    logic       clr_cnt;  // reset point count
    logic       load_pre; // capture prelude vertex into hold register
    logic       load_pt;  // capture current point into hold register
    logic       flush;    // mark held vertex as last and release it
    logic       step;     // advance walk index
    logic       start;    // begin walk at index 0
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       match;    // current point matches a pattern
    pre_e       pre;      // kind of prelude vertex
    logic       walk_done;
    logic       out_busy; // output register cannot accept
    logic       held;     // a vertex is held back awaiting successor
  } sts_t;

endpackage

// ===== design/gcv_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcv_ctrl: contour flattener controller
// Sequences point capture, the end-of-contour walk and vertex emission.
// ----------------------------------------------------------------------------
module gcv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           contour_end_i,
  output logic           in_stall_o,
  input  gcv_pkg::sts_t  sts_i,
  output gcv_pkg::cmd_t  cmd_o
);

  gcv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcv_pkg::StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      gcv_pkg::StCollect: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (contour_end_i) begin
            cmd_o.start = 1'b1;
            state_d     = gcv_pkg::StEval;
          end
        end
      end
      gcv_pkg::StEval: begin
        if (sts_i.walk_done) begin
          state_d = gcv_pkg::StWaitFinal;
        end else if (!sts_i.match) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.pre != gcv_pkg::PreNone) begin
          state_d = gcv_pkg::StEmitPre;
        end else begin
          state_d = gcv_pkg::StEmitPt;
        end
      end
      gcv_pkg::StEmitPre: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_pre = 1'b1;
          state_d        = gcv_pkg::StEmitPt;
        end
      end
      gcv_pkg::StEmitPt: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_pt = 1'b1;
          cmd_o.step    = 1'b1;
          state_d       = gcv_pkg::StEval;
        end
      end
      gcv_pkg::StWaitFinal: begin
        if (!sts_i.held) begin
          cmd_o.clr_cnt = 1'b1;
          state_d       = gcv_pkg::StCollect;
        end else if (!sts_i.out_busy) begin
          cmd_o.flush   = 1'b1;
          cmd_o.clr_cnt = 1'b1;
          state_d       = gcv_pkg::StCollect;
        end
      end
      default: state_d = gcv_pkg::StCollect;
    endcase
  end

endmodule

// ===== design/gcv_datapath.sv =====
// ----------------------------------------------------------------------------
// gcv_datapath: contour flattener datapath
// Point store, pattern match, midpoint/cubic arithmetic and output stage.
// A vertex is held one step so the last one can be flagged.
// ----------------------------------------------------------------------------
module gcv_datapath #(
  parameter int unsigned MaxPoints = gcv_pkg::MaxPointsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [gcv_pkg::CoordW-1:0]   point_x_i,
  input  logic signed [gcv_pkg::CoordW-1:0]   point_y_i,
  input  logic        [gcv_pkg::TagW-1:0]     point_tag_i,
  input  gcv_pkg::cmd_t                       cmd_i,
  output gcv_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gcv_pkg::VertW-1:0]    vertex_x_o,
  output logic signed [gcv_pkg::VertW-1:0]    vertex_y_o,
  output logic                                last_vertex_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned PosW = CntW + 1;
  localparam int unsigned CW   = gcv_pkg::CoordW;
  localparam int unsigned VW   = gcv_pkg::VertW;

  logic signed [CW-1:0] x_mem [MaxPoints];
  logic signed [CW-1:0] y_mem [MaxPoints];
  logic [gcv_pkg::TagW-1:0] tag_mem [MaxPoints];

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] r_q;

  // held vertex (not yet released) and output register
  logic                 hold_v_q;
  logic signed [VW-1:0] hold_x_q, hold_y_q;
  logic                 out_v_q, out_last_q;
  logic signed [VW-1:0] out_x_q, out_y_q;

  // store write
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (cnt_q < CntW'(MaxPoints))) begin
      x_mem[cnt_q[IdxW-1:0]]   <= point_x_i;
      y_mem[cnt_q[IdxW-1:0]]   <= point_y_i;
      tag_mem[cnt_q[IdxW-1:0]] <= point_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      r_q   <= '0;
    end else begin
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.store && (cnt_q < CntW'(MaxPoints))) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.start) begin
        r_q <= '0;
      end else if (cmd_i.step) begin
        r_q <= r_q + 1'b1;
      end
    end
  end

  // pattern match on contour-relative positions
  logic signed [PosW-1:0] pos_r, pos_l;
  assign pos_r = $signed({1'b0, r_q});
  assign pos_l = $signed({1'b0, cnt_q}) - PosW'(1);

  function automatic logic tag_at(input logic signed [PosW-1:0] k,
                                  input logic signed [PosW-1:0] n,
                                  input logic [gcv_pkg::TagW-1:0] want,
                                  input logic [gcv_pkg::TagW-1:0] t);
    return (k >= 0) && (k < n) && (t == want);
  endfunction

  logic signed [PosW-1:0] pn;
  assign pn = $signed({1'b0, cnt_q});

  function automatic logic [IdxW-1:0] ix(input logic signed [PosW-1:0] k);
    return k[IdxW-1:0];
  endfunction

  logic signed [PosW-1:0] p_l1, p_l2, p_r1, p_r2, p_r3;
  assign p_l1 = pos_l - PosW'(1);
  assign p_l2 = pos_l - PosW'(2);
  assign p_r1 = pos_r - PosW'(1);
  assign p_r2 = pos_r - PosW'(2);
  assign p_r3 = pos_r - PosW'(3);

  logic [gcv_pkg::TagW-1:0] t_r, t_l, t_l1, t_l2, t_r1, t_r2, t_r3, t_0, t_1;
  assign t_r  = tag_mem[ix(pos_r)];
  assign t_l  = tag_mem[ix(pos_l)];
  assign t_l1 = tag_mem[ix(p_l1)];
  assign t_l2 = tag_mem[ix(p_l2)];
  assign t_r1 = tag_mem[ix(p_r1)];
  assign t_r2 = tag_mem[ix(p_r2)];
  assign t_r3 = tag_mem[ix(p_r3)];
  assign t_0  = tag_mem[ix(PosW'(0))];
  assign t_1  = tag_mem[ix(PosW'(1))];

  localparam logic [gcv_pkg::TagW-1:0] ON = gcv_pkg::TagOn;
  localparam logic [gcv_pkg::TagW-1:0] CO = gcv_pkg::TagConic;
  localparam logic [gcv_pkg::TagW-1:0] CU = gcv_pkg::TagCubic;

  logic is_r0, is_r1, is_r2;
  assign is_r0 = (pos_r == 0);
  assign is_r1 = (pos_r == 1);
  assign is_r2 = (pos_r == 2);

  logic on_r, l_on, l_co, l_cu, l1_on, l1_co, l1_cu, l2_on;
  logic r1_on, r1_co, r1_cu, r2_on, r2_co, r2_cu, r3_on;
  logic z_co, z_cu, o_co, o_cu;
  assign on_r  = tag_at(pos_r, pn, ON, t_r);
  assign l_on  = tag_at(pos_l, pn, ON, t_l);
  assign l_co  = tag_at(pos_l, pn, CO, t_l);
  assign l_cu  = tag_at(pos_l, pn, CU, t_l);
  assign l1_on = tag_at(p_l1, pn, ON, t_l1);
  assign l1_co = tag_at(p_l1, pn, CO, t_l1);
  assign l1_cu = tag_at(p_l1, pn, CU, t_l1);
  assign l2_on = tag_at(p_l2, pn, ON, t_l2);
  assign r1_on = tag_at(p_r1, pn, ON, t_r1);
  assign r1_co = tag_at(p_r1, pn, CO, t_r1);
  assign r1_cu = tag_at(p_r1, pn, CU, t_r1);
  assign r2_on = tag_at(p_r2, pn, ON, t_r2);
  assign r2_co = tag_at(p_r2, pn, CO, t_r2);
  assign r2_cu = tag_at(p_r2, pn, CU, t_r2);
  assign r3_on = tag_at(p_r3, pn, ON, t_r3);
  assign z_co  = tag_at(PosW'(0), pn, CO, t_0);
  assign z_cu  = tag_at(PosW'(0), pn, CU, t_0);
  assign o_co  = tag_at(PosW'(1), pn, CO, t_1);
  assign o_cu  = tag_at(PosW'(1), pn, CU, t_1);

  // operand indices for prelude: a,b (mid) or a,b,c,d (cubic)
  logic              match;
  gcv_pkg::pre_e     pre;
  logic [IdxW-1:0]   ia, ib, ic, id;

  always_comb begin
    match = 1'b0;
    pre   = gcv_pkg::PreNone;
    ia = '0; ib = '0; ic = '0; id = '0;
    if (on_r) begin
      match = 1'b1;
      if (is_r0 && l_on) begin
      end else if (is_r0 && l_co && l1_on) begin
      end else if (is_r0 && l_co && l1_co && l2_on) begin
        pre = gcv_pkg::PreMid; ia = ix(p_l1); ib = ix(pos_l);
      end else if (is_r0 && l_cu && l1_cu && l2_on) begin
        pre = gcv_pkg::PreCubic;
        ia = ix(p_l2); ib = ix(p_l1); ic = ix(pos_l); id = ix(pos_r);
      end else if (!is_r0 && r1_on) begin
      end else if (is_r1 && z_co && l_on) begin
      end else if (is_r1 && z_co && l_co && l1_on) begin
        pre = gcv_pkg::PreMid; ia = ix(pos_l); ib = '0;
      end else if (is_r1 && z_cu && l_cu && l1_on) begin
        pre = gcv_pkg::PreCubic;
        ia = ix(p_l1); ib = ix(pos_l); ic = '0; id = ix(pos_r);
      end else if (pos_r >= 2 && r1_co && r2_on) begin
      end else if (is_r2 && o_co && z_co && l_on) begin
        pre = gcv_pkg::PreMid; ia = '0; ib = ix(PosW'(1));
      end else if (is_r2 && o_cu && z_cu && l_on) begin
        pre = gcv_pkg::PreCubic;
        ia = ix(pos_l); ib = '0; ic = ix(PosW'(1)); id = ix(pos_r);
      end else if (pos_r >= 3 && r1_co && r2_co && r3_on) begin
        pre = gcv_pkg::PreMid; ia = ix(p_r2); ib = ix(p_r1);
      end else if (pos_r >= 3 && r1_cu && r2_cu && r3_on) begin
        pre = gcv_pkg::PreCubic;
        ia = ix(p_r3); ib = ix(p_r2); ic = ix(p_r1); id = ix(pos_r);
      end else begin
        match = 1'b0;
      end
    end
  end

  // prelude arithmetic
  function automatic logic signed [VW-1:0] mid8(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    logic signed [CW:0] h;
    s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    h = (s + $signed({{CW{1'b0}}, s[CW]})) >>> 1;
    return VW'(h) <<< 3;
  endfunction

  function automatic logic signed [VW-1:0] cub(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b,
                                               input logic signed [CW-1:0] c,
                                               input logic signed [CW-1:0] d);
    logic signed [VW-1:0] bc;
    bc = VW'(b) + VW'(c);
    return VW'(a) + bc + (bc <<< 1) + VW'(d);
  endfunction

  logic signed [VW-1:0] pre_x, pre_y, pt_x, pt_y;
  always_comb begin
    if (pre == gcv_pkg::PreCubic) begin
      pre_x = cub(x_mem[ia], x_mem[ib], x_mem[ic], x_mem[id]);
      pre_y = cub(y_mem[ia], y_mem[ib], y_mem[ic], y_mem[id]);
    end else begin
      pre_x = mid8(x_mem[ia], x_mem[ib]);
      pre_y = mid8(y_mem[ia], y_mem[ib]);
    end
    pt_x = VW'(x_mem[r_q[IdxW-1:0]]) <<< 3;
    pt_y = VW'(y_mem[r_q[IdxW-1:0]]) <<< 3;
  end

  // prelude registered every cycle; it holds while the walk index stays put
  logic signed [VW-1:0] pre_x_q, pre_y_q;
  always_ff @(posedge clk_i) begin
    pre_x_q <= pre_x;
    pre_y_q <= pre_y;
  end

  logic out_busy, new_v, push;
  logic signed [VW-1:0] new_x, new_y;
  assign out_busy = out_v_q && out_stall_i;
  assign new_v = cmd_i.load_pre || cmd_i.load_pt;
  assign new_x = cmd_i.load_pre ? pre_x_q : pt_x;
  assign new_y = cmd_i.load_pre ? pre_y_q : pt_y;
  assign push  = (new_v && hold_v_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q    <= 1'b1;
        out_last_q <= cmd_i.flush;
      end
      if (new_v) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_v) begin
      hold_x_q <= new_x;
      hold_y_q <= new_y;
    end
    if (push) begin
      out_x_q <= hold_x_q;
      out_y_q <= hold_y_q;
    end
  end

  assign sts_o.match     = match;
  assign sts_o.pre       = pre;
  assign sts_o.walk_done = (r_q >= cnt_q);
  assign sts_o.out_busy  = out_busy;
  assign sts_o.held      = hold_v_q;

  assign out_valid_o   = out_v_q;
  assign vertex_x_o    = out_x_q;
  assign vertex_y_o    = out_y_q;
  assign last_vertex_o = out_last_q;

endmodule

// ===== design/glyph_contour_to_vertices_top.sv =====
// After the last point the controller walks the store, evaluating each stored
// point in turn and emitting each vertex, then finishes and releases the held
// last vertex; output stalls stretch the walk.
// Throughput: one point per cycle while collecting; the walk blocks input.
// Reset clears point count, controller and output valid; the store is not cleared.
// ----------------------------------------------------------------------------
// glyph_contour_to_vertices_top: glyph contour flattener
// Stores a contour, then emits polygon vertices with conic midpoints and
// cubic samples.
// ----------------------------------------------------------------------------
module glyph_contour_to_vertices_top #(
  parameter int unsigned MaxPoints = gcv_pkg::MaxPointsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [gcv_pkg::CoordW-1:0] point_x_i,
  input  logic signed [gcv_pkg::CoordW-1:0] point_y_i,
  input  logic        [gcv_pkg::TagW-1:0]   point_tag_i,
  input  logic                              contour_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [gcv_pkg::VertW-1:0]  vertex_x_o,
  output logic signed [gcv_pkg::VertW-1:0]  vertex_y_o,
  output logic                              last_vertex_o
);

  gcv_pkg::cmd_t cmd;
  gcv_pkg::sts_t sts;

  gcv_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .contour_end_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  gcv_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i,
    .rst_ni,
    .point_x_i,
    .point_y_i,
    .point_tag_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .out_valid_o,
    .out_stall_i,
    .vertex_x_o,
    .vertex_y_o,
    .last_vertex_o
  );

endmodule

// ===== dv/glyph_contour_to_vertices_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_contour_to_vertices_checker: vertex predictor and scoreboard
// Watches the point and vertex channels, keeps its own copy of the contour
// store, flattens each finished contour and compares every vertex word.
// ----------------------------------------------------------------------------
module glyph_contour_to_vertices_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [gcv_pkg::CoordW-1:0] point_x_i,
  input  logic signed [gcv_pkg::CoordW-1:0] point_y_i,
  input  logic        [gcv_pkg::TagW-1:0]   point_tag_i,
  input  logic                              contour_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [gcv_pkg::VertW-1:0]  vertex_x_i,
  input  logic signed [gcv_pkg::VertW-1:0]  vertex_y_i,
  input  logic                              last_vertex_i,
  output int                                fail_cnt_o,
  output int                                pending_o,
  output int                                vertex_cnt_o
);

  localparam int Depth = gcv_pkg::MaxPointsDefault;

  typedef struct packed {
    logic signed [gcv_pkg::VertW-1:0] x;
    logic signed [gcv_pkg::VertW-1:0] y;
    logic                             last;
  } vertex_t;

  logic signed [gcv_pkg::CoordW-1:0] pts_x [Depth];
  logic signed [gcv_pkg::CoordW-1:0] pts_y [Depth];
  logic        [gcv_pkg::TagW-1:0]   pts_tag [Depth];
  int                                num_pts;
  vertex_t                           vertex_q [$];

  assign pending_o = vertex_q.size();

  function automatic bit tag_at(int k, logic [gcv_pkg::TagW-1:0] want);
    return k >= 0 && k < num_pts && pts_tag[k] == want;
  endfunction

  function automatic void push_vtx(longint x, longint y);
    vertex_t v;
    v.x = x[gcv_pkg::VertW-1:0];
    v.y = y[gcv_pkg::VertW-1:0];
    v.last = 1'b0;
    vertex_q.push_back(v);
  endfunction

  function automatic void push_pt(int k);
    push_vtx(longint'(pts_x[k]) * 8, longint'(pts_y[k]) * 8);
  endfunction

  function automatic void push_mid(int a, int b);
    longint mx, my;
    mx = (longint'(pts_x[a]) + longint'(pts_x[b])) / 2;
    my = (longint'(pts_y[a]) + longint'(pts_y[b])) / 2;
    push_vtx(mx * 8, my * 8);
  endfunction

  function automatic void push_cubic(int a, int b, int c, int d);
    push_vtx(longint'(pts_x[a]) + 3 * longint'(pts_x[b]) + 3 * longint'(pts_x[c])
             + longint'(pts_x[d]),
             longint'(pts_y[a]) + 3 * longint'(pts_y[b]) + 3 * longint'(pts_y[c])
             + longint'(pts_y[d]));
  endfunction

  function automatic void flatten_contour();
    int lst, base;
    lst = num_pts - 1;
    base = vertex_q.size();
    for (int r = 0; r < num_pts; r++) begin
      if (!tag_at(r, gcv_pkg::TagOn)) continue;
      if (r == 0 && tag_at(lst, gcv_pkg::TagOn)) begin
        push_pt(r);
      end else if (r == 0 && tag_at(lst, gcv_pkg::TagConic)
                   && tag_at(lst-1, gcv_pkg::TagOn)) begin
        push_pt(r);
      end else if (r == 0 && tag_at(lst, gcv_pkg::TagConic)
                   && tag_at(lst-1, gcv_pkg::TagConic) && tag_at(lst-2, gcv_pkg::TagOn)) begin
        push_mid(lst-1, lst); push_pt(r);
      end else if (r == 0 && tag_at(lst, gcv_pkg::TagCubic)
                   && tag_at(lst-1, gcv_pkg::TagCubic) && tag_at(lst-2, gcv_pkg::TagOn)) begin
        push_cubic(lst-2, lst-1, lst, r); push_pt(r);
      end else if (r >= 1 && tag_at(r-1, gcv_pkg::TagOn)) begin
        push_pt(r);
      end else if (r == 1 && tag_at(0, gcv_pkg::TagConic) && tag_at(lst, gcv_pkg::TagOn)) begin
        push_pt(r);
      end else if (r == 1 && tag_at(0, gcv_pkg::TagConic) && tag_at(lst, gcv_pkg::TagConic)
                   && tag_at(lst-1, gcv_pkg::TagOn)) begin
        push_mid(lst, 0); push_pt(r);
      end else if (r == 1 && tag_at(0, gcv_pkg::TagCubic) && tag_at(lst, gcv_pkg::TagCubic)
                   && tag_at(lst-1, gcv_pkg::TagOn)) begin
        push_cubic(lst-1, lst, 0, r); push_pt(r);
      end else if (r >= 2 && tag_at(r-1, gcv_pkg::TagConic)
                   && tag_at(r-2, gcv_pkg::TagOn)) begin
        push_pt(r);
      end else if (r == 2 && tag_at(1, gcv_pkg::TagConic) && tag_at(0, gcv_pkg::TagConic)
                   && tag_at(lst, gcv_pkg::TagOn)) begin
        push_mid(0, 1); push_pt(r);
      end else if (r == 2 && tag_at(1, gcv_pkg::TagCubic) && tag_at(0, gcv_pkg::TagCubic)
                   && tag_at(lst, gcv_pkg::TagOn)) begin
        push_cubic(lst, 0, 1, r); push_pt(r);
      end else if (r >= 3 && tag_at(r-1, gcv_pkg::TagConic) && tag_at(r-2, gcv_pkg::TagConic)
                   && tag_at(r-3, gcv_pkg::TagOn)) begin
        push_mid(r-2, r-1); push_pt(r);
      end else if (r >= 3 && tag_at(r-1, gcv_pkg::TagCubic) && tag_at(r-2, gcv_pkg::TagCubic)
                   && tag_at(r-3, gcv_pkg::TagOn)) begin
        push_cubic(r-3, r-2, r-1, r); push_pt(r);
      end
    end
    if (vertex_q.size() > base) vertex_q[vertex_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t exp_v;
    if (!rst_ni) begin
      num_pts = 0;
      fail_cnt_o <= 0;
      vertex_cnt_o <= 0;
      vertex_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        vertex_cnt_o <= vertex_cnt_o + 1;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex word x=%0d y=%0d", vertex_x_i, vertex_y_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (vertex_x_i !== exp_v.x) begin
            $error("vertex_x expected %0d actual %0d", exp_v.x, vertex_x_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end else if (vertex_y_i !== exp_v.y) begin
            $error("vertex_y expected %0d actual %0d", exp_v.y, vertex_y_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end else if (last_vertex_i !== exp_v.last) begin
            $error("last_vertex expected %0d actual %0d", exp_v.last, last_vertex_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (num_pts < Depth) begin
          pts_x[num_pts] = point_x_i;
          pts_y[num_pts] = point_y_i;
          pts_tag[num_pts] = point_tag_i;
          num_pts = num_pts + 1;
        end
        if (contour_end_i) begin
          flatten_contour();
          num_pts = 0;
        end
      end
    end
  end
endmodule

// ===== dv/glyph_contour_to_vertices_top_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_contour_to_vertices_top_tb: contour flattener testbench
// Drives directed and random contours with random gaps and output stalls;
// the checker predicts the vertex stream and counts mismatches.
// ----------------------------------------------------------------------------
module glyph_contour_to_vertices_top_tb;

  localparam int WatchLimit = 20000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [gcv_pkg::CoordW-1:0] point_x_i = '0;
  logic signed [gcv_pkg::CoordW-1:0] point_y_i = '0;
  logic        [gcv_pkg::TagW-1:0]   point_tag_i = gcv_pkg::TagOn;
  logic                              contour_end_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [gcv_pkg::VertW-1:0]  vertex_x_o, vertex_y_o;
  logic                              last_vertex_o;
  int                                fail_cnt, pending, vertex_cnt;
  int                                idle_cnt = 0;
  int                                contour_cnt = 0;
  int                                point_cnt = 0;
  bit                                stall_on = 1'b1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  glyph_contour_to_vertices_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .point_x_i, .point_y_i,
    .point_tag_i, .contour_end_i, .out_valid_o, .out_stall_i,
    .vertex_x_o, .vertex_y_o, .last_vertex_o
  );

  glyph_contour_to_vertices_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .point_x_i, .point_y_i,
    .point_tag_i, .contour_end_i, .out_valid_i(out_valid_o), .out_stall_i,
    .vertex_x_i(vertex_x_o), .vertex_y_i(vertex_y_o), .last_vertex_i(last_vertex_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .vertex_cnt_o(vertex_cnt)
  );

  // output stall bursts
  always @(posedge clk_i) begin
    if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("watchdog expired");
      $display("FAIL glyph_contour_to_vertices_top");
      $finish;
    end
  end

  task automatic send_point(input logic signed [gcv_pkg::CoordW-1:0] x,
                            input logic signed [gcv_pkg::CoordW-1:0] y,
                            input logic [gcv_pkg::TagW-1:0] tag, input bit last,
                            input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_tag_i <= tag;
    contour_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    point_cnt++;
    if (last) contour_cnt++;
  endtask

  function automatic logic signed [gcv_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(gcv_pkg::CoordW-1){1'b0}}};
      1: return {1'b0, {(gcv_pkg::CoordW-1){1'b1}}};
      2: return gcv_pkg::CoordW'($signed($urandom_range(0, 200)) - 100);
      default: return gcv_pkg::CoordW'($urandom);
    endcase
  endfunction

  function automatic logic [gcv_pkg::TagW-1:0] rand_tag();
    int k;
    k = $urandom_range(0, 19);
    if (k < 9) return gcv_pkg::TagOn;
    if (k < 14) return gcv_pkg::TagConic;
    if (k < 19) return gcv_pkg::TagCubic;
    return gcv_pkg::TagUnused;
  endfunction

  task automatic send_contour(input int len, input bit gaps);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), rand_tag(), i == len - 1, gaps);
  endtask

  // well-formed outline: on points with conic or cubic-pair runs between
  task automatic send_outline(input bit gaps);
    logic [gcv_pkg::TagW-1:0] tags [$];
    int segs;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      tags.push_back(gcv_pkg::TagOn);
      case ($urandom_range(0, 3))
        1: tags.push_back(gcv_pkg::TagConic);
        2: begin tags.push_back(gcv_pkg::TagConic); tags.push_back(gcv_pkg::TagConic); end
        3: begin tags.push_back(gcv_pkg::TagCubic); tags.push_back(gcv_pkg::TagCubic); end
        default: ;
      endcase
    end
    // rotate so patterns also start off-curve
    repeat ($urandom_range(0, 2)) tags.push_back(tags.pop_front());
    foreach (tags[i])
      send_point(rand_coord(), rand_coord(), tags[i], i == tags.size() - 1, gaps);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes and several start/wrap patterns
    send_point({1'b1, 23'd0}, {1'b0, {23{1'b1}}}, gcv_pkg::TagOn, 1'b0, 1'b0);
    send_point({1'b0, {23{1'b1}}}, {1'b1, 23'd0}, gcv_pkg::TagConic, 1'b0, 1'b0);
    send_point(-24'sd3, 24'sd5, gcv_pkg::TagConic, 1'b0, 1'b0);
    send_point(24'sd7, -24'sd9, gcv_pkg::TagOn, 1'b0, 1'b0);
    send_point(-24'sd1, -24'sd1, gcv_pkg::TagCubic, 1'b0, 1'b0);
    send_point(24'sd1, 24'sd1, gcv_pkg::TagCubic, 1'b1, 1'b0);
    send_point(24'sd4, 24'sd4, gcv_pkg::TagConic, 1'b0, 1'b0);
    send_point(24'sd5, 24'sd5, gcv_pkg::TagOn, 1'b0, 1'b0);
    send_point(24'sd6, 24'sd6, gcv_pkg::TagOn, 1'b0, 1'b0);
    send_point(24'sd8, 24'sd8, gcv_pkg::TagConic, 1'b1, 1'b0);
    send_point(24'sd1, 24'sd2, gcv_pkg::TagCubic, 1'b0, 1'b0);
    send_point(24'sd3, 24'sd4, gcv_pkg::TagCubic, 1'b0, 1'b0);
    send_point(24'sd5, 24'sd6, gcv_pkg::TagOn, 1'b0, 1'b0);
    send_point(24'sd9, 24'sd9, gcv_pkg::TagOn, 1'b1, 1'b0);
    send_point(24'sd1, 24'sd1, gcv_pkg::TagUnused, 1'b0, 1'b0);
    send_point(24'sd2, 24'sd2, gcv_pkg::TagConic, 1'b1, 1'b0);
    send_point(24'sd7, 24'sd7, gcv_pkg::TagOn, 1'b1, 1'b0);
    wait_drain();
    // overflow: 35 on points, the last three dropped
    for (int i = 0; i < 35; i++)
      send_point(gcv_pkg::CoordW'(i * 1000 - 17000), gcv_pkg::CoordW'(-i), gcv_pkg::TagOn,
                 i == 34, 1'b1);
    wait_drain();
    while (point_cnt < 300) begin
      if ($urandom_range(0, 3) == 0) send_contour($urandom_range(1, 12), 1'b1);
      else send_outline(1'b1);
    end
    wait_drain();
    stall_on = 1'b0;
    while (point_cnt < 370) send_outline(1'b0);
    wait_drain();
    repeat (200) @(posedge clk_i);
    $display("sent %0d points in %0d contours, %0d vertices checked",
             point_cnt, contour_cnt, vertex_cnt);
    $display("covered extreme coordinates, all tags, wrapped patterns and overflow");
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS glyph_contour_to_vertices_top");
    end else begin
      $display("FAIL glyph_contour_to_vertices_top");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/gcv_pkg.sv
design/gcv_ctrl.sv
design/gcv_datapath.sv
design/glyph_contour_to_vertices_top.sv
dv/glyph_contour_to_vertices_checker.sv
dv/glyph_contour_to_vertices_top_tb.sv
